/* design/gmd_pkg.sv */
`default_nettype none

package gmd_pkg;

    localparam int GRID_DIM_DEF = 32;
    localparam int SUM_W        = 48;
    localparam int OUT_ADDR_W   = 15;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [2:0]  TYPE_LIMIT = 3'd3;
    localparam logic [31:0] CELLS_PER_LENGTH_RST = 32'd65536;
    localparam logic [31:0] UNIT_SCALE_RST       = 32'd65536;

    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_PER_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_SCALE       = CFG_INDEX_W'(1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_ADDR,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_LO,
        MUL_HI
    } mul_op_t;

    typedef struct packed {
        logic    clear_wr;
        logic    load_in;
        mul_op_t mul_op;
        logic    addr_en;
        logic    ram_re;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_read;
        logic req_in_range;
        logic mode_read;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* design/gmd_ram.sv */
`default_nettype none

module gmd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/gmd_ctrl.sv */
`default_nettype none

module gmd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gmd_pkg::stat_t stat,
    output gmd_pkg::cmd_t      cmd
);

    gmd_pkg::state_t state_reg;
    gmd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gmd_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gmd_pkg::ST_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = gmd_pkg::ST_IDLE;
                end
            end
            gmd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (!stat.req_read) begin
                        state_next = gmd_pkg::ST_MUL_X;
                    end else if (stat.req_in_range) begin
                        state_next = gmd_pkg::ST_READ;
                    end else begin
                        state_next = gmd_pkg::ST_FINISH;
                    end
                end
            end
            gmd_pkg::ST_MUL_X:  state_next = gmd_pkg::ST_MUL_Y;
            gmd_pkg::ST_MUL_Y:  state_next = gmd_pkg::ST_MUL_Z;
            gmd_pkg::ST_MUL_Z:  state_next = gmd_pkg::ST_ADDR;
            gmd_pkg::ST_ADDR:   state_next = gmd_pkg::ST_READ;
            gmd_pkg::ST_READ: begin
                state_next = stat.mode_read ? gmd_pkg::ST_MUL_LO : gmd_pkg::ST_FINISH;
            end
            gmd_pkg::ST_MUL_LO: state_next = gmd_pkg::ST_MUL_HI;
            gmd_pkg::ST_MUL_HI: state_next = gmd_pkg::ST_FINISH;
            gmd_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = gmd_pkg::ST_IDLE;
                end
            end
            default: state_next = gmd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.mul_op = gmd_pkg::MUL_NONE;
        s_ready = 1'b0;
        case (state_reg)
            gmd_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
            gmd_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            gmd_pkg::ST_MUL_X:  cmd.mul_op = gmd_pkg::MUL_X;
            gmd_pkg::ST_MUL_Y:  cmd.mul_op = gmd_pkg::MUL_Y;
            gmd_pkg::ST_MUL_Z:  cmd.mul_op = gmd_pkg::MUL_Z;
            gmd_pkg::ST_ADDR:   cmd.addr_en = 1'b1;
            gmd_pkg::ST_READ:   cmd.ram_re = 1'b1;
            gmd_pkg::ST_MUL_LO: cmd.mul_op = gmd_pkg::MUL_LO;
            gmd_pkg::ST_MUL_HI: cmd.mul_op = gmd_pkg::MUL_HI;
            gmd_pkg::ST_FINISH: cmd.finish = stat.out_free;
            default: ;
        endcase
    end

    // one item in flight: an accepted transfer always closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

endmodule

`default_nettype wire

/* design/gmd_datapath.sv */
`default_nettype none

module gmd_datapath #(
    parameter int GRID_DIM = gmd_pkg::GRID_DIM_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire gmd_pkg::cmd_t                   cmd,
    output gmd_pkg::stat_t                       stat,
    input  wire logic                            cfg_we,
    input  wire logic [gmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            s_mode,
    input  wire logic [31:0]                     s_pos_x,
    input  wire logic [31:0]                     s_pos_y,
    input  wire logic [31:0]                     s_pos_z,
    input  wire logic [2:0]                      s_galaxy_type,
    input  wire logic                            s_is_ghost,
    input  wire logic [31:0]                     s_stellar_mass,
    input  wire logic [14:0]                     s_read_address,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [63:0]                          m_cell_value,
    output logic [14:0]                          m_cell_address,
    output logic                                 m_deposited,
    output logic                                 m_saturated
);

    localparam int NUM_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AXIS_W    = $clog2(GRID_DIM);
    localparam int ADDR_W    = $clog2(NUM_CELLS);
    localparam int EXT_W     = (ADDR_W > gmd_pkg::OUT_ADDR_W) ? ADDR_W : gmd_pkg::OUT_ADDR_W;
    localparam int SW        = gmd_pkg::SUM_W;

    // configuration
    logic [31:0] cpl_reg;
    logic [31:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpl_reg   <= gmd_pkg::CELLS_PER_LENGTH_RST;
            scale_reg <= gmd_pkg::UNIT_SCALE_RST;
        end else if (cfg_we) begin
            if (cfg_index == gmd_pkg::REG_CELLS_PER_LENGTH) begin
                cpl_reg <= cfg_data;
            end else if (cfg_index == gmd_pkg::REG_UNIT_SCALE) begin
                scale_reg <= cfg_data;
            end
        end
    end

    // clearing sweep after reset
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // captured item
    logic              mode_reg;
    logic [31:0]       pos_x_reg;
    logic [31:0]       pos_y_reg;
    logic [31:0]       pos_z_reg;
    logic [2:0]        type_reg;
    logic              ghost_reg;
    logic [31:0]       mass_reg;
    logic [14:0]       raddr_reg;
    logic              in_range_reg;
    logic [AXIS_W-1:0] ix_reg;
    logic [AXIS_W-1:0] iy_reg;
    logic [AXIS_W-1:0] iz_reg;
    logic              sat_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [63:0]       plo_reg;
    logic [47:0]       phi_reg;

    logic [EXT_W-1:0]  raddr_ext;
    logic              req_in_range;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic              axis_clamp;
    logic [AXIS_W-1:0] axis_idx;
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] lin_addr;
    logic [SW-1:0]     ram_q;

    assign raddr_ext    = EXT_W'(s_read_address);
    assign req_in_range = 32'(s_read_address) < 32'(NUM_CELLS);

    always_comb begin
        mul_a = 32'd0;
        mul_b = cpl_reg;
        case (cmd.mul_op)
            gmd_pkg::MUL_X:  mul_a = pos_x_reg;
            gmd_pkg::MUL_Y:  mul_a = pos_y_reg;
            gmd_pkg::MUL_Z:  mul_a = pos_z_reg;
            gmd_pkg::MUL_LO: begin
                mul_a = ram_q[31:0];
                mul_b = scale_reg;
            end
            gmd_pkg::MUL_HI: begin
                mul_a = 32'(ram_q[SW-1:32]);
                mul_b = scale_reg;
            end
            default: mul_a = 32'd0;
        endcase
    end

    assign prod       = 64'(mul_a) * 64'(mul_b);
    assign axis_clamp = prod[63:32] >= 32'(GRID_DIM);
    assign axis_idx   = axis_clamp ? AXIS_W'(GRID_DIM - 1) : prod[32 +: AXIS_W];

    assign row_addr = ADDR_W'(ix_reg) * ADDR_W'(GRID_DIM) + ADDR_W'(iy_reg);
    assign lin_addr = row_addr * ADDR_W'(GRID_DIM) + ADDR_W'(iz_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg     <= s_mode;
            pos_x_reg    <= s_pos_x;
            pos_y_reg    <= s_pos_y;
            pos_z_reg    <= s_pos_z;
            type_reg     <= s_galaxy_type;
            ghost_reg    <= s_is_ghost;
            mass_reg     <= s_stellar_mass;
            raddr_reg    <= s_read_address;
            in_range_reg <= req_in_range;
            sat_reg      <= 1'b0;
            addr_reg     <= raddr_ext[ADDR_W-1:0];
        end
        case (cmd.mul_op)
            gmd_pkg::MUL_X: begin
                ix_reg  <= axis_idx;
                sat_reg <= sat_reg | axis_clamp;
            end
            gmd_pkg::MUL_Y: begin
                iy_reg  <= axis_idx;
                sat_reg <= sat_reg | axis_clamp;
            end
            gmd_pkg::MUL_Z: begin
                iz_reg  <= axis_idx;
                sat_reg <= sat_reg | axis_clamp;
            end
            gmd_pkg::MUL_LO: plo_reg <= prod;
            gmd_pkg::MUL_HI: phi_reg <= prod[47:0];
            default: ;
        endcase
        if (cmd.addr_en) begin
            addr_reg <= lin_addr;
        end
    end

    // finish step: update the cell and build the result
    logic          eligible;
    logic [SW:0]   dep_sum;
    logic          sum_ovf;
    logic [SW-1:0] dep_val;
    logic [63:0]   scaled;
    logic          do_write;
    logic [SW-1:0] fin_wdata;
    logic [EXT_W-1:0] addr_ext;

    assign eligible = (type_reg < gmd_pkg::TYPE_LIMIT) && !ghost_reg;
    assign dep_sum  = {1'b0, ram_q} + (SW + 1)'(mass_reg);
    assign sum_ovf  = dep_sum[SW];
    assign dep_val  = sum_ovf ? {SW{1'b1}} : dep_sum[SW-1:0];
    assign scaled   = (64'(phi_reg) << 16) + (plo_reg >> 16);
    assign addr_ext = EXT_W'(addr_reg);

    always_comb begin
        if (mode_reg) begin
            do_write  = cmd.finish && in_range_reg;
            fin_wdata = '0;
        end else begin
            do_write  = cmd.finish && eligible;
            fin_wdata = dep_val;
        end
    end

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SW-1:0]     ram_wdata;

    assign ram_we    = cmd.clear_wr || do_write;
    assign ram_waddr = cmd.clear_wr ? clr_addr_reg : addr_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : fin_wdata;

    gmd_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_re),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // result register
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [63:0] m_value_reg;
    logic [14:0] m_addr_reg;
    logic        m_dep_reg;
    logic        m_sat_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (mode_reg) begin
                m_value_reg <= in_range_reg ? scaled : 64'd0;
                m_addr_reg  <= raddr_reg;
                m_dep_reg   <= 1'b0;
                m_sat_reg   <= !in_range_reg;
            end else begin
                m_value_reg <= 64'd0;
                m_addr_reg  <= addr_ext[gmd_pkg::OUT_ADDR_W-1:0];
                m_dep_reg   <= eligible;
                m_sat_reg   <= sat_reg | (eligible & sum_ovf);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_value   = m_value_reg;
    assign m_cell_address = m_addr_reg;
    assign m_deposited    = m_dep_reg;
    assign m_saturated    = m_sat_reg;

    assign stat.clear_last   = clr_addr_reg == ADDR_W'(NUM_CELLS - 1);
    assign stat.req_read     = s_mode;
    assign stat.req_in_range = req_in_range;
    assign stat.mode_read    = mode_reg;
    assign stat.out_free     = !m_valid_reg || m_ready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_deposit_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dep_reg) |-> (m_value_reg == 64'd0))
        else $error("deposit result carries a cell value");

    a_clear_isolated: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !(cmd.load_in || cmd.finish || cmd.ram_re))
        else $error("item activity during clearing sweep");

endmodule

`default_nettype wire

/* design/grid_mass_deposit_unit.sv */
// Nearest-grid-point mass deposit over a GRID_DIM^3 cell grid held in one
// block RAM of 48-bit sums. After reset the unit sweeps the grid to zero, one
// cell per cycle, through all GRID_DIM^3 cells (32768 at the default size);
// s_ready stays low until the sweep ends, while configuration writes are taken
// as usual. One item is processed at a time, paced by the single shared 32x32
// multiplier and the registered RAM read. A deposit steps through three axis
// products, address, RAM read and update; an in-range read-and-clear through
// RAM read, two partial products of the scale and combine; an out-of-range read
// goes straight to its final step. The result sits in an output register, so
// the unit returns to accepting while an earlier result waits, and only stalls
// its final step if a second result would overwrite one not yet taken.
`default_nettype none

module grid_mass_deposit_unit #(
    parameter int GRID_DIM = gmd_pkg::GRID_DIM_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [gmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [31:0]                     s_pos_x,
    input  wire logic [31:0]                     s_pos_y,
    input  wire logic [31:0]                     s_pos_z,
    input  wire logic [2:0]                      s_galaxy_type,
    input  wire logic                            s_is_ghost,
    input  wire logic [31:0]                     s_stellar_mass,
    input  wire logic [14:0]                     s_read_address,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [63:0]                          m_cell_value,
    output logic [14:0]                          m_cell_address,
    output logic                                 m_deposited,
    output logic                                 m_saturated
);

    gmd_pkg::cmd_t  cmd;
    gmd_pkg::stat_t stat;

    gmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gmd_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_mode         (s_mode),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_galaxy_type  (s_galaxy_type),
        .s_is_ghost     (s_is_ghost),
        .s_stellar_mass (s_stellar_mass),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_value   (m_cell_value),
        .m_cell_address (m_cell_address),
        .m_deposited    (m_deposited),
        .m_saturated    (m_saturated)
    );

endmodule

`default_nettype wire
